// ----- rtl/core/plsd_pkg.sv -----
// Shared types, constants and helpers for the parallel LED strip driver.
// No dependencies; plsd_cfg, plsd_gather and the top level import this package.
`timescale 1ns / 1ps

package plsd_pkg;

  localparam int unsigned STRIPS_DEF = 32;
  localparam int unsigned LEDS_DEF   = 360;

  localparam int unsigned PINS     = 32;
  localparam int unsigned PIN_W    = 5;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STRIP_FW = 5;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned BITS     = 8;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] REG_HIGH = 2'd0;
  localparam logic [1:0] REG_DATA = 2'd1;
  localparam logic [1:0] REG_LOW  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] high;
    logic [SLOT_W-1:0] data;
    logic [SLOT_W-1:0] low;
  } slot_cfg_t;

  typedef logic [BITS-1:0][PINS-1:0] planes_t;

  // A slot count of zero behaves as one.
  function automatic logic [SLOT_W-1:0] slots_of(input logic [SLOT_W-1:0] v);
    return (v == '0) ? SLOT_W'(1) : v;
  endfunction

endpackage

// ----- rtl/core/plsd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module plsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/plsd_cfg.sv -----
// APB-style register file holding the three slot counts.
// Depends on plsd_pkg.
`timescale 1ns / 1ps

module plsd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plsd_pkg::PADDR_W-1:0] paddr,
  input  logic [plsd_pkg::PDATA_W-1:0] pwdata,
  output logic [plsd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output plsd_pkg::slot_cfg_t         cfg_o
);
  import plsd_pkg::*;

  slot_cfg_t  cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high <= SLOT_W'(1);
      cfg_q.data <= SLOT_W'(1);
      cfg_q.low  <= SLOT_W'(2);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HIGH: cfg_q.high <= pwdata[SLOT_W-1:0];
        REG_DATA: cfg_q.data <= pwdata[SLOT_W-1:0];
        REG_LOW:  cfg_q.low  <= pwdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIGH: prdata = PDATA_W'(cfg_q.high);
      REG_DATA: prdata = PDATA_W'(cfg_q.data);
      REG_LOW:  prdata = PDATA_W'(cfg_q.low);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/plsd_gather.sv -----
// Gather engine: reads one byte position of every strip from the pixel store
// and transposes it into eight bit planes. Depends on plsd_pkg.
`timescale 1ns / 1ps

module plsd_gather #(
  parameter int unsigned STRIPS         = plsd_pkg::STRIPS_DEF,
  parameter int unsigned LEDS_PER_STRIP = plsd_pkg::LEDS_DEF,
  localparam int unsigned ROW_BYTES = 3 * LEDS_PER_STRIP,
  localparam int unsigned STRIP_W   = (STRIPS > 1) ? $clog2(STRIPS) : 1,
  localparam int unsigned BPOS_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1,
  localparam int unsigned DEPTH     = ROW_BYTES * (2 ** STRIP_W),
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [BPOS_W-1:0]   byte_pos_i,
  output logic                busy_o,
  output logic                re_o,
  output logic [AW-1:0]       raddr_o,
  input  logic [7:0]          rdata_i,
  output plsd_pkg::planes_t   planes_o
);
  import plsd_pkg::*;

  localparam int unsigned CNT_W = STRIP_W + 1;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [PIN_W-1:0] rd_idx_q;
  planes_t          planes_q;
  logic             issue;

  assign issue   = busy_q && (32'(cnt_q) < STRIPS);
  assign re_o    = issue;
  assign raddr_o = AW'({byte_pos_i, cnt_q[STRIP_W-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      planes_q <= '0;
    end else begin
      rd_vld_q <= issue;
      rd_idx_q <= PIN_W'(cnt_q);
      if (start_i) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        planes_q <= '0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        // MSB of each byte lands in plane 0
        if (rd_vld_q) begin
          for (int b = 0; b < BITS; b++) begin
            planes_q[b][rd_idx_q] <= rdata_i[BITS-1-b];
          end
        end
        if (busy_q && !issue && rd_vld_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o   = busy_q;
  assign planes_o = planes_q;

endmodule

// ----- rtl/core/parallel_led_strip_driver.sv -----
// Parallel LED strip driver: top level with the slot sequencer and pixel store.
// Depends on plsd_pkg, plsd_ram, plsd_cfg and plsd_gather.
`timescale 1ns / 1ps

// Drives up to 32 LED strips in parallel from a byte store with one row per
// strip. Every accepted beat gives exactly one result beat. The tick that opens
// a new byte position reads that byte from every strip through the store's
// single read port, one strip per cycle, and stalls the input after it is taken
// until that read is done. After reset the store is cleared one byte per cycle,
// all 3*LEDS_PER_STRIP*2^ceil(log2(STRIPS)) bytes (34560 with default
// parameters); no input beat is taken until that pass ends, while register
// writes are accepted at any time.
module parallel_led_strip_driver #(
  parameter int unsigned STRIPS         = plsd_pkg::STRIPS_DEF,
  parameter int unsigned LEDS_PER_STRIP = plsd_pkg::LEDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plsd_pkg::PADDR_W-1:0]  paddr,
  input  logic [plsd_pkg::PDATA_W-1:0]  pwdata,
  output logic [plsd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [plsd_pkg::KIND_W-1:0]   kind_i,
  input  logic [plsd_pkg::STRIP_FW-1:0] strip_i,
  input  logic [plsd_pkg::INDEX_W-1:0]  byte_index_i,
  input  logic [plsd_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [plsd_pkg::PINS-1:0]     pin_word_o,
  output logic                          busy_res_o,
  output logic                          frame_done_o
);
  import plsd_pkg::*;

  localparam int unsigned ROW_BYTES = 3 * LEDS_PER_STRIP;
  localparam int unsigned STRIP_W   = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int unsigned BPOS_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int unsigned DEPTH     = ROW_BYTES * (2 ** STRIP_W);
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PINS-1:0] PIN_MASK =
    (STRIPS >= PINS) ? '1 : PINS'((64'd1 << STRIPS) - 64'd1);

  typedef enum logic {ST_CLEAR, ST_RUN} state_e;
  typedef enum logic [1:0] {PH_HIGH, PH_DATA, PH_LOW} phase_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              active_q, active_d;
  phase_e            phase_q, phase_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [2:0]        bit_q, bit_d;
  logic [BPOS_W-1:0] bpos_q, bpos_d;
  logic [PINS-1:0]   pins_q, pins_d;
  logic              out_valid_q, out_valid_d;
  logic [PINS-1:0]   res_pins_q, res_pins_d;
  logic              res_busy_q, res_busy_d;
  logic              res_done_q, res_done_d;

  slot_cfg_t         cfg;
  planes_t           planes;
  logic              gath_start, gath_busy, gath_re;
  logic [AW-1:0]     gath_raddr;
  logic [7:0]        ram_rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              accept;
  logic [SLOT_W-1:0] limit;
  logic [SLOT_W:0]   slot_next;
  logic [BPOS_W:0]   bpos_next;

  plsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plsd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (gath_re),
    .raddr_i (gath_raddr),
    .rdata_o (ram_rdata)
  );

  plsd_gather #(
    .STRIPS         (STRIPS),
    .LEDS_PER_STRIP (LEDS_PER_STRIP)
  ) u_gather (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (gath_start),
    .byte_pos_i (bpos_q),
    .busy_o     (gath_busy),
    .re_o       (gath_re),
    .raddr_o    (gath_raddr),
    .rdata_i    (ram_rdata),
    .planes_o   (planes)
  );

  assign in_stall_o = (state_q != ST_RUN) || gath_busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    active_d    = active_q;
    phase_d     = phase_q;
    slot_d      = slot_q;
    bit_d       = bit_q;
    bpos_d      = bpos_q;
    pins_d      = pins_q;
    res_pins_d  = res_pins_q;
    res_busy_d  = res_busy_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = AW'({byte_index_i, strip_i[STRIP_W-1:0]});
    ram_wdata   = value_i;
    gath_start  = 1'b0;
    limit       = slots_of(cfg.low);
    slot_next   = {1'b0, slot_q} + (SLOT_W+1)'(1);
    bpos_next   = {1'b0, bpos_q} + (BPOS_W+1)'(1);

    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
      clr_d     = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        state_d = ST_RUN;
      end
    end else if (accept) begin
      out_valid_d = 1'b1;
      res_pins_d  = pins_q;
      res_busy_d  = active_q;
      res_done_d  = 1'b0;
      priority if (kind_i == KIND_WRITE) begin
        ram_we = (32'(strip_i) < STRIPS) && (32'(byte_index_i) < ROW_BYTES);
      end else if (kind_i == KIND_COMMIT) begin
        if (!active_q) begin
          active_d = 1'b1;
          phase_d  = PH_HIGH;
          slot_d   = '0;
          bit_d    = '0;
          bpos_d   = '0;
        end
        res_busy_d = 1'b1;
      end else if (kind_i == KIND_TICK && active_q) begin
        // load the bit planes on the first slot of each byte position
        gath_start = (phase_q == PH_HIGH) && (slot_q == '0) && (bit_q == '0);
        unique case (phase_q)
          PH_HIGH: begin
            pins_d = PIN_MASK;
            limit  = slots_of(cfg.high);
          end
          PH_DATA: begin
            pins_d = planes[bit_q];
            limit  = slots_of(cfg.data);
          end
          default: begin
            pins_d = '0;
            limit  = slots_of(cfg.low);
          end
        endcase
        res_pins_d = pins_d;
        res_busy_d = 1'b1;
        slot_d     = slot_next[SLOT_W-1:0];
        if (slot_next >= {1'b0, limit}) begin
          slot_d = '0;
          unique case (phase_q)
            PH_HIGH: phase_d = PH_DATA;
            PH_DATA: phase_d = PH_LOW;
            default: begin
              phase_d = PH_HIGH;
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                if (32'(bpos_next) >= ROW_BYTES) begin
                  bpos_d     = '0;
                  active_d   = 1'b0;
                  res_done_d = 1'b1;
                end else begin
                  bpos_d = bpos_next[BPOS_W-1:0];
                end
              end
            end
          endcase
        end
      end else begin
        res_busy_d = active_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      active_q    <= 1'b0;
      phase_q     <= PH_HIGH;
      slot_q      <= '0;
      bit_q       <= '0;
      bpos_q      <= '0;
      pins_q      <= '0;
      out_valid_q <= 1'b0;
      res_pins_q  <= '0;
      res_busy_q  <= 1'b0;
      res_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      active_q    <= active_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      bit_q       <= bit_d;
      bpos_q      <= bpos_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
      res_pins_q  <= res_pins_d;
      res_busy_q  <= res_busy_d;
      res_done_q  <= res_done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pin_word_o   = res_pins_q;
  assign busy_res_o   = res_busy_q;
  assign frame_done_o = res_done_q;

endmodule
